>>> rtl/binomial_inversion_sampler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binomial inversion sampler
// Wrap concurrent assertions so they can be dropped with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_INVERSION_SAMPLER_DEFINES_SVH
`define BINOMIAL_INVERSION_SAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion, off while reset is held
`define BIS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("binomial_inversion_sampler: assertion failed");
// Clocked assertion, checked during reset as well
`define BIS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("binomial_inversion_sampler: assertion failed");
`else
`define BIS_ASSERT(lbl, clk, rst_n, prop)
`define BIS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared widths, datapath command codes and the status bundle.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int TRIALS_W  = 8;
    localparam int PROB_W    = 17;
    localparam int UNIFORM_W = 16;
    localparam int MUL_W     = 32;

    // 1.0 in the Q1.16 probability format
    localparam logic [PROB_W-1:0] Q16_ONE = 17'h10000;

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NOP          = 5'd0;
    localparam t_cmd CMD_LOAD         = 5'd1;
    localparam t_cmd CMD_SET_X_N      = 5'd2;
    localparam t_cmd CMD_SET_X_ONE    = 5'd3;
    localparam t_cmd CMD_DIV_S_START  = 5'd4;
    localparam t_cmd CMD_DIV_STEP     = 5'd5;
    localparam t_cmd CMD_SET_S        = 5'd6;
    localparam t_cmd CMD_MUL_A_LO     = 5'd7;
    localparam t_cmd CMD_TAKE_A_LO    = 5'd8;
    localparam t_cmd CMD_MUL_A_HI     = 5'd9;
    localparam t_cmd CMD_TAKE_A_HI    = 5'd10;
    localparam t_cmd CMD_MUL_POW_ACC  = 5'd11;
    localparam t_cmd CMD_TAKE_POW_ACC = 5'd12;
    localparam t_cmd CMD_MUL_POW_SQ   = 5'd13;
    localparam t_cmd CMD_TAKE_POW_SQ  = 5'd14;
    localparam t_cmd CMD_STEP_X       = 5'd15;
    localparam t_cmd CMD_DIV_Q_START  = 5'd16;
    localparam t_cmd CMD_SET_F        = 5'd17;
    localparam t_cmd CMD_MUL_F_LO     = 5'd18;
    localparam t_cmd CMD_TAKE_F_LO    = 5'd19;
    localparam t_cmd CMD_MUL_F_HI     = 5'd20;
    localparam t_cmd CMD_TAKE_F_HI    = 5'd21;
    localparam t_cmd CMD_CLIP         = 5'd22;

    typedef struct packed {
        logic n_zero;
        logic p_one;
        logic n_one;
        logic u_le_p;
        logic div_done;
        logic e_zero;
        logic e_lsb;
        logic u_gt_r;
        logic x_ge_n;
    } t_dp_status;

endpackage

>>> rtl/bis_datapath.sv
// ----------------------------------------------------------------------------
// bis_datapath
// Operand registers, shared 32x32 multiplier and radix-4 divider.
// ----------------------------------------------------------------------------
module bis_datapath import bis_pkg::*; #(
    parameter int MAX_TRIALS = 255,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  t_cmd                 i_cmd,
    input  logic [TRIALS_W-1:0]  i_trials,
    input  logic [PROB_W-1:0]    i_prob,
    input  logic [UNIFORM_W-1:0] i_uniform,
    output t_dp_status           o_status,
    output logic [TRIALS_W-1:0]  o_successes,
    output logic                 o_clipped
);

    localparam int F   = FRAC_BITS;
    localparam int SW  = F + 16;          // s = p/q
    localparam int AW  = F + 25;          // a = (n+1)s and f
    localparam int NST = (AW + 1) / 2;    // radix-4 steps
    localparam int DW  = 2 * NST;
    localparam int PW  = AW + F + 1;      // f * r
    localparam int CW  = $clog2(NST + 1);

    localparam logic [F:0]  FX_ONE = {1'b1, {F{1'b0}}};
    localparam logic [AW:0] SAT_LIM = (AW + 1)'(1) << F;

    logic [TRIALS_W-1:0]  r_n;
    logic [PROB_W-1:0]    r_p;
    logic [PROB_W-1:0]    r_q;
    logic                 r_ule;
    logic [F-1:0]         r_u;
    logic [F:0]           r_r;
    logic [F:0]           r_base;
    logic [TRIALS_W-1:0]  r_e;
    logic [TRIALS_W-1:0]  r_x;
    logic                 r_clip;
    logic [SW-1:0]        r_s;
    logic [AW-1:0]        r_a;
    logic [AW-1:0]        r_f;
    logic [PW-1:0]        r_acc;
    logic [2*MUL_W-1:0]   r_prod;
    logic [DW-1:0]        r_dq;
    logic [PROB_W-1:0]    r_drem;
    logic [PROB_W-1:0]    r_dvs;
    logic [CW-1:0]        r_dcnt;

    logic [TRIALS_W-1:0]  n_clamp;
    logic [PROB_W-1:0]    q_in;
    logic [PROB_W+F-1:0]  q_ext;
    logic [UNIFORM_W+F-1:0] u_ext;
    logic [TRIALS_W:0]    n_plus1;
    logic [AW-1:0]        s_ext;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic [PROB_W+1:0]    div_sh;
    logic [PROB_W+1:0]    div_d1;
    logic [PROB_W+1:0]    div_d2;
    logic [PROB_W+1:0]    div_d3;
    logic [PROB_W+1:0]    div_rem;
    logic [1:0]           div_digit;
    logic [PW-1:0]        f_total;
    logic [AW:0]          f_shift;

    assign n_clamp = (32'(i_trials) > MAX_TRIALS) ? TRIALS_W'(MAX_TRIALS) : i_trials;
    assign q_in    = Q16_ONE - i_prob;
    assign q_ext   = {q_in, {F{1'b0}}};
    assign u_ext   = {i_uniform, {F{1'b0}}};
    assign n_plus1 = {1'b0, r_n} + 1'b1;
    assign s_ext   = AW'(r_s);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd)
            CMD_MUL_A_LO: begin
                mul_a = MUL_W'(n_plus1);
                mul_b = s_ext[MUL_W-1:0];
            end
            CMD_MUL_A_HI: begin
                mul_a = MUL_W'(n_plus1);
                mul_b = MUL_W'(s_ext[AW-1:MUL_W]);
            end
            CMD_MUL_POW_ACC: begin
                mul_a = MUL_W'(r_r);
                mul_b = MUL_W'(r_base);
            end
            CMD_MUL_POW_SQ: begin
                mul_a = MUL_W'(r_base);
                mul_b = MUL_W'(r_base);
            end
            CMD_MUL_F_LO: begin
                mul_a = r_f[MUL_W-1:0];
                mul_b = MUL_W'(r_r);
            end
            CMD_MUL_F_HI: begin
                mul_a = MUL_W'(r_f[AW-1:MUL_W]);
                mul_b = MUL_W'(r_r);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one radix-4 quotient digit per step
    always_comb begin
        div_sh = {r_drem, r_dq[DW-1:DW-2]};
        div_d1 = (PROB_W + 2)'(r_dvs);
        div_d2 = div_d1 << 1;
        div_d3 = div_d1 + div_d2;
        priority if (div_sh >= div_d3) begin
            div_digit = 2'd3;
            div_rem   = div_sh - div_d3;
        end else if (div_sh >= div_d2) begin
            div_digit = 2'd2;
            div_rem   = div_sh - div_d2;
        end else if (div_sh >= div_d1) begin
            div_digit = 2'd1;
            div_rem   = div_sh - div_d1;
        end else begin
            div_digit = 2'd0;
            div_rem   = div_sh;
        end
    end

    // next term: floor(f*r / 2^F), held at 1.0
    assign f_total = r_acc + PW'({r_prod, {MUL_W{1'b0}}});
    assign f_shift = f_total[PW-1:F];

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_n    <= n_clamp;
                r_p    <= i_prob;
                r_q    <= q_in;
                r_ule  <= ({1'b0, i_uniform} <= i_prob);
                r_u    <= u_ext[UNIFORM_W+F-1:UNIFORM_W];
                r_r    <= FX_ONE;
                r_base <= q_ext[PROB_W+F-1:UNIFORM_W];
                r_e    <= n_clamp;
                r_x    <= '0;
                r_clip <= 1'b0;
            end
            CMD_SET_X_N:   r_x <= r_n;
            CMD_SET_X_ONE: r_x <= TRIALS_W'(1);
            CMD_DIV_S_START: begin
                r_dq   <= DW'({r_p, {F{1'b0}}});
                r_drem <= '0;
                r_dvs  <= r_q;
                r_dcnt <= CW'(NST);
            end
            CMD_DIV_Q_START: begin
                r_dq   <= DW'(r_a);
                r_drem <= '0;
                r_dvs  <= PROB_W'(r_x);
                r_dcnt <= CW'(NST);
            end
            CMD_DIV_STEP: begin
                r_dq   <= {r_dq[DW-3:0], div_digit};
                r_drem <= div_rem[PROB_W-1:0];
                r_dcnt <= r_dcnt - 1'b1;
            end
            CMD_SET_S:        r_s <= r_dq[SW-1:0];
            CMD_MUL_A_LO,
            CMD_MUL_A_HI,
            CMD_MUL_POW_ACC,
            CMD_MUL_POW_SQ,
            CMD_MUL_F_LO,
            CMD_MUL_F_HI:     r_prod <= mul_p;
            CMD_TAKE_A_LO:    r_a <= r_prod[AW-1:0];
            CMD_TAKE_A_HI:    r_a <= r_a + {r_prod[AW-MUL_W-1:0], {MUL_W{1'b0}}};
            CMD_TAKE_POW_ACC: r_r <= r_prod[2*F:F];
            CMD_TAKE_POW_SQ: begin
                r_base <= r_prod[2*F:F];
                r_e    <= r_e >> 1;
            end
            CMD_STEP_X: begin
                r_u <= r_u - r_r[F-1:0];
                r_x <= r_x + 1'b1;
            end
            CMD_SET_F:        r_f <= r_dq[AW-1:0] - s_ext;
            CMD_TAKE_F_LO:    r_acc <= PW'(r_prod);
            CMD_TAKE_F_HI:    r_r <= (f_shift > SAT_LIM) ? FX_ONE : f_shift[F:0];
            CMD_CLIP:         r_clip <= 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.n_zero   = (r_n == '0);
        o_status.p_one    = r_p[PROB_W-1];
        o_status.n_one    = (r_n == TRIALS_W'(1));
        o_status.u_le_p   = r_ule;
        o_status.div_done = (r_dcnt == '0);
        o_status.e_zero   = (r_e == '0);
        o_status.e_lsb    = r_e[0];
        o_status.u_gt_r   = ({1'b0, r_u} > r_r);
        o_status.x_ge_n   = (r_x >= r_n);
    end

    assign o_successes = r_x;
    assign o_clipped   = r_clip;

endmodule

>>> rtl/bis_controller.sv
// ----------------------------------------------------------------------------
// bis_controller
// Sequencer issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module bis_controller import bis_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    input  logic       i_out_free,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SPECIAL   = 5'd1;
    localparam logic [4:0] S_DIVS_RUN  = 5'd2;
    localparam logic [4:0] S_A_LO_M    = 5'd3;
    localparam logic [4:0] S_A_LO_T    = 5'd4;
    localparam logic [4:0] S_A_HI_M    = 5'd5;
    localparam logic [4:0] S_A_HI_T    = 5'd6;
    localparam logic [4:0] S_POW_CHECK = 5'd7;
    localparam logic [4:0] S_POW_ACC_M = 5'd8;
    localparam logic [4:0] S_POW_ACC_T = 5'd9;
    localparam logic [4:0] S_POW_SQ_M  = 5'd10;
    localparam logic [4:0] S_POW_SQ_T  = 5'd11;
    localparam logic [4:0] S_LOOP      = 5'd12;
    localparam logic [4:0] S_DIVQ_INIT = 5'd13;
    localparam logic [4:0] S_DIVQ_RUN  = 5'd14;
    localparam logic [4:0] S_F_LO_M    = 5'd15;
    localparam logic [4:0] S_F_LO_T    = 5'd16;
    localparam logic [4:0] S_F_HI_M    = 5'd17;
    localparam logic [4:0] S_F_HI_T    = 5'd18;
    localparam logic [4:0] S_FINISH    = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_SPECIAL;
                end
            end
            S_SPECIAL: begin
                priority if (i_status.n_zero) begin
                    n_state = S_FINISH;
                end else if (i_status.p_one) begin
                    o_cmd   = CMD_SET_X_N;
                    n_state = S_FINISH;
                end else if (i_status.n_one) begin
                    o_cmd   = i_status.u_le_p ? CMD_SET_X_ONE : CMD_NOP;
                    n_state = S_FINISH;
                end else begin
                    o_cmd   = CMD_DIV_S_START;
                    n_state = S_DIVS_RUN;
                end
            end
            S_DIVS_RUN: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SET_S;
                    n_state = S_A_LO_M;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            S_A_LO_M: begin
                o_cmd   = CMD_MUL_A_LO;
                n_state = S_A_LO_T;
            end
            S_A_LO_T: begin
                o_cmd   = CMD_TAKE_A_LO;
                n_state = S_A_HI_M;
            end
            S_A_HI_M: begin
                o_cmd   = CMD_MUL_A_HI;
                n_state = S_A_HI_T;
            end
            S_A_HI_T: begin
                o_cmd   = CMD_TAKE_A_HI;
                n_state = S_POW_CHECK;
            end
            S_POW_CHECK: begin
                priority if (i_status.e_zero) begin
                    n_state = S_LOOP;
                end else if (i_status.e_lsb) begin
                    n_state = S_POW_ACC_M;
                end else begin
                    n_state = S_POW_SQ_M;
                end
            end
            S_POW_ACC_M: begin
                o_cmd   = CMD_MUL_POW_ACC;
                n_state = S_POW_ACC_T;
            end
            S_POW_ACC_T: begin
                o_cmd   = CMD_TAKE_POW_ACC;
                n_state = S_POW_SQ_M;
            end
            S_POW_SQ_M: begin
                o_cmd   = CMD_MUL_POW_SQ;
                n_state = S_POW_SQ_T;
            end
            S_POW_SQ_T: begin
                o_cmd   = CMD_TAKE_POW_SQ;
                n_state = S_POW_CHECK;
            end
            S_LOOP: begin
                priority if (!i_status.u_gt_r) begin
                    n_state = S_FINISH;
                end else if (i_status.x_ge_n) begin
                    o_cmd   = CMD_CLIP;
                    n_state = S_FINISH;
                end else begin
                    o_cmd   = CMD_STEP_X;
                    n_state = S_DIVQ_INIT;
                end
            end
            S_DIVQ_INIT: begin
                o_cmd   = CMD_DIV_Q_START;
                n_state = S_DIVQ_RUN;
            end
            S_DIVQ_RUN: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SET_F;
                    n_state = S_F_LO_M;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            S_F_LO_M: begin
                o_cmd   = CMD_MUL_F_LO;
                n_state = S_F_LO_T;
            end
            S_F_LO_T: begin
                o_cmd   = CMD_TAKE_F_LO;
                n_state = S_F_HI_M;
            end
            S_F_HI_M: begin
                o_cmd   = CMD_MUL_F_HI;
                n_state = S_F_HI_T;
            end
            S_F_HI_T: begin
                o_cmd   = CMD_TAKE_F_HI;
                n_state = S_LOOP;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/binomial_inversion_sampler.sv
// ----------------------------------------------------------------------------
// binomial_inversion_sampler
// Zero trials, certain success and a single trial finish without the search.
// In the general case the run time grows with k, the successes returned; the
// divider takes NST = (FRAC_BITS + 26) / 2 radix-4 steps (21 at FRAC_BITS = 16).
// The per-success term update (divide, two partial products) sets the rate.
// Throughput: one beat at a time; the next beat is taken once the result moves
// to the output register. Synchronous active-low reset empties the block.
// ----------------------------------------------------------------------------
// Binomial variate by sequential inversion. The controller walks the
// datapath through: special-case check, s = p/q on the shared divider,
// a = (n+1)s on the shared multiplier in two halves, q^n by square and
// multiply, then the search loop. Each loop pass subtracts the current
// term from u, advances x and forms the next term from a/x - s times r.
// The finished result sits in an output register, so a stalled consumer
// only holds the controller in its final state.
// ----------------------------------------------------------------------------
`include "binomial_inversion_sampler_defines.svh"

module binomial_inversion_sampler import bis_pkg::*; #(
    parameter int MAX_TRIALS = 255,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TRIALS_W-1:0]  i_trials,
    input  logic [PROB_W-1:0]    i_prob,
    input  logic [UNIFORM_W-1:0] i_uniform,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [TRIALS_W-1:0]  o_successes,
    output logic                 o_clipped
);

    t_cmd                dp_cmd;
    t_dp_status          dp_status;
    logic                ctl_busy;
    logic                ctl_done;
    logic                in_beat;
    logic                out_free;
    logic [TRIALS_W-1:0] dp_successes;
    logic                dp_clipped;

    logic                r_out_valid;
    logic [TRIALS_W-1:0] r_out_successes;
    logic                r_out_clipped;

    // take a beat only while the sequencer is idle
    assign o_stall  = ctl_busy;
    assign in_beat  = i_valid && !ctl_busy;
    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_stall;

    bis_controller u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_beat),
        .i_status   (dp_status),
        .i_out_free (out_free),
        .o_cmd      (dp_cmd),
        .o_busy     (ctl_busy),
        .o_done     (ctl_done)
    );

    bis_datapath #(
        .MAX_TRIALS (MAX_TRIALS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .i_trials    (i_trials),
        .i_prob      (i_prob),
        .i_uniform   (i_uniform),
        .o_status    (dp_status),
        .o_successes (dp_successes),
        .o_clipped   (dp_clipped)
    );

    // output register: hold while stalled, load on completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_done) begin
            r_out_successes <= dp_successes;
            r_out_clipped   <= dp_clipped;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_successes = r_out_successes;
    assign o_clipped   = r_out_clipped;

    `BIS_ASSERT(a_done_needs_room, i_clk, i_rst_n, ctl_done |-> out_free)
    `BIS_ASSERT(a_beat_makes_busy, i_clk, i_rst_n, in_beat |=> ctl_busy)
    `BIS_ASSERT(a_clip_means_search, i_clk, i_rst_n, r_out_valid && r_out_clipped |-> r_out_successes >= TRIALS_W'(2))
    `BIS_ASSERT_ALWAYS(a_reset_empties, i_clk, !$past(i_rst_n) |-> !r_out_valid && !ctl_busy)

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Binomial inversion sampler testbench
// Drives trial counts, probabilities and uniform draws through the sampler,
// predicts each variate with a fixed-point inversion search of its own and
// checks every result beat in order, under four sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
    import bis_pkg::*;

    localparam int MAX_N  = 255;
    localparam int FBITS  = 16;
    localparam int N_RAND = 1680;

    typedef struct packed {
        logic [TRIALS_W-1:0]  trials;
        logic [PROB_W-1:0]    prob;
        logic [UNIFORM_W-1:0] uniform;
    } t_draw;

    typedef struct packed {
        logic [TRIALS_W-1:0] successes;
        logic                clipped;
    } t_variate;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [TRIALS_W-1:0]  i_trials;
    logic [PROB_W-1:0]    i_prob;
    logic [UNIFORM_W-1:0] i_uniform;
    logic                 o_valid;
    logic                 i_stall;
    logic [TRIALS_W-1:0]  o_successes;
    logic                 o_clipped;

    t_draw    pending_draws[$];
    t_variate expected_variates[$];
    int       n_draws_total;
    int       n_draws_sent;
    int       n_errors;
    logic     draw_taken;

    binomial_inversion_sampler #(.MAX_TRIALS(MAX_N), .FRAC_BITS(FBITS)) dut (.*);

    // floor(x*y / 2^F)
    function automatic bit [63:0] fx_mul(bit [63:0] x, bit [63:0] y);
        return (x * y) >> FBITS;
    endfunction

    // floor(big*r / 2^F), held at 1.0
    function automatic bit [63:0] fx_mul_clamp(bit [63:0] big, bit [63:0] r);
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] res;
        hi = (big >> 32) * r;
        lo = (big & 64'hFFFF_FFFF) * r;
        if (hi >= (64'd1 << (FBITS + 2)))
            return 64'd1 << FBITS;
        res = (hi << (32 - FBITS)) + (lo >> FBITS);
        return (res > (64'd1 << FBITS)) ? (64'd1 << FBITS) : res;
    endfunction

    // Walk the mass function from zero successes upward until u fits
    function automatic t_variate binv_draw(t_draw d);
        t_variate  v;
        int        n;
        int        e;
        bit [63:0] p;
        bit [63:0] q;
        bit [63:0] u;
        bit [63:0] s;
        bit [63:0] a;
        bit [63:0] r;
        bit [63:0] base;
        int        x;
        n = d.trials;
        if (n > MAX_N)
            n = MAX_N;
        p = d.prob;
        x = 0;
        v.clipped = 1'b0;
        if (n == 0) begin
            x = 0;
        end else if (p >= Q16_ONE) begin
            x = n;
        end else if (n == 1) begin
            x = (d.uniform <= p) ? 1 : 0;
        end else begin
            q = 64'd65536 - p;
            base = (q << FBITS) >> 16;
            u = (64'(d.uniform) << FBITS) >> 16;
            s = (p << FBITS) / q;
            a = 64'(n + 1) * s;
            // q^n, least significant exponent bit first
            r = 64'd1 << FBITS;
            e = n;
            while (e != 0) begin
                if (e & 1)
                    r = fx_mul(r, base);
                base = fx_mul(base, base);
                e = e >> 1;
            end
            while (u > r) begin
                if (x >= n) begin
                    v.clipped = 1'b1;
                    break;
                end
                u = u - r;
                x++;
                r = fx_mul_clamp(a / 64'(x) - s, r);
            end
        end
        v.successes = x[TRIALS_W-1:0];
        return v;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample both handshakes; check result beats against the oldest prediction
    always @(posedge i_clk) begin
        t_variate want;
        draw_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_variates.size() == 0) begin
                $display("%0t: unexpected result successes=%0d clipped=%0d",
                         $time, o_successes, o_clipped);
                n_errors++;
            end else begin
                want = expected_variates.pop_front();
                if (o_successes !== want.successes) begin
                    $display("%0t: successes expected %0d actual %0d",
                             $time, want.successes, o_successes);
                    n_errors++;
                end
                if (o_clipped !== want.clipped) begin
                    $display("%0t: clipped expected %0d actual %0d",
                             $time, want.clipped, o_clipped);
                    n_errors++;
                end
            end
        end
        if (draw_taken)
            expected_variates.push_back(binv_draw({i_trials, i_prob, i_uniform}));
    end

    // Phase 0 no idling, 1 sender idle 78%, 2 receiver stalls 78%, 3 both 6%
    always @(negedge i_clk) begin
        int phase;
        int idle_pct;
        int stall_pct;
        t_draw d;
        phase = (n_draws_total == 0) ? 0 : (n_draws_sent * 4) / n_draws_total;
        idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 6 : 0;
        stall_pct = (phase == 2) ? 78 : (phase == 3) ? 6 : 0;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < stall_pct);
            // hold the beat while it waits; advance once it is taken
            if (!i_valid || draw_taken) begin
                if (pending_draws.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    d = pending_draws.pop_front();
                    i_trials  <= d.trials;
                    i_prob    <= d.prob;
                    i_uniform <= d.uniform;
                    i_valid   <= 1'b1;
                    n_draws_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    function automatic t_draw mk_draw(int n, int p, int u);
        t_draw d;
        d.trials = TRIALS_W'(n);
        d.prob = PROB_W'(p);
        d.uniform = UNIFORM_W'(u);
        return d;
    endfunction

    initial begin
        t_draw d;
        int    k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_trials = '0;
        i_prob = '0;
        i_uniform = '0;
        draw_taken = 1'b0;
        n_errors = 0;
        n_draws_sent = 0;

        // zero trials, certain success (at and above 1.0), single trial either side
        pending_draws.push_back(mk_draw(0, 30000, 65535));
        pending_draws.push_back(mk_draw(255, 65536, 0));
        pending_draws.push_back(mk_draw(7, 131071, 65535));
        pending_draws.push_back(mk_draw(1, 30000, 30000));
        pending_draws.push_back(mk_draw(1, 30000, 30001));
        pending_draws.push_back(mk_draw(1, 0, 0));
        pending_draws.push_back(mk_draw(1, 65535, 65535));
        // general path extremes; long searches and likely exhausted searches
        pending_draws.push_back(mk_draw(2, 0, 65535));
        pending_draws.push_back(mk_draw(2, 65535, 0));
        pending_draws.push_back(mk_draw(2, 65535, 65535));
        pending_draws.push_back(mk_draw(255, 1, 65535));
        pending_draws.push_back(mk_draw(255, 65535, 65535));
        pending_draws.push_back(mk_draw(255, 32768, 32768));
        pending_draws.push_back(mk_draw(255, 100, 0));
        pending_draws.push_back(mk_draw(200, 60000, 65535));
        pending_draws.push_back(mk_draw(128, 49151, 21845));
        pending_draws.push_back(mk_draw(64, 65000, 65535));
        pending_draws.push_back(mk_draw(3, 65534, 65535));

        // mostly small trial counts keep the search short; a few large ones
        for (k = 0; k < N_RAND; k++) begin
            d.uniform = UNIFORM_W'($urandom_range(65535));
            case ($urandom_range(9))
                0: d.trials = TRIALS_W'($urandom_range(255));
                1: d.trials = TRIALS_W'($urandom_range(1));
                default: d.trials = TRIALS_W'($urandom_range(2, 24));
            endcase
            case ($urandom_range(15))
                0: d.prob = PROB_W'($urandom_range(65536, 131071));
                1: d.prob = PROB_W'($urandom_range(255));
                2: d.prob = PROB_W'($urandom_range(65280, 65535));
                default: d.prob = PROB_W'($urandom_range(65535));
            endcase
            if (d.trials > 24 && $urandom_range(1))
                d.prob = PROB_W'($urandom_range(6000));
            pending_draws.push_back(d);
        end
        n_draws_total = pending_draws.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_draws.size() == 0 && i_valid && draw_taken);
        @(posedge i_clk);
        wait (expected_variates.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
